FILE: rtl/core/p224ms_pkg.sv
`default_nettype none
package p224ms_pkg;

    localparam int unsigned LIMB_W  = 64;
    localparam int unsigned TOP_W   = 32;
    localparam int unsigned FE_W    = 224;
    localparam int unsigned DIG_W   = 32;
    localparam int unsigned NDIG    = FE_W / DIG_W;
    localparam int unsigned NSTG    = 10;

    // Accumulator widths before and after each reduction round
    localparam int unsigned ACC0_W  = 448;
    localparam int unsigned ACC1_W  = 385;
    localparam int unsigned ACC2_W  = 322;
    localparam int unsigned ACC3_W  = 259;
    localparam int unsigned ACC4_W  = 225;

    // m * p = m * 2^224 - m * 2^96 + m, seen after the one-word shift
    localparam int unsigned M_HI_SH = 160;
    localparam int unsigned M_LO_SH = 32;

    localparam logic [FE_W-1:0] P224 =
        {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 64'h1};

    typedef logic [ACC0_W-1:0] row_t;
    typedef logic [DIG_W-1:0]  digit_t;

endpackage
`default_nettype wire

FILE: rtl/core/p224ms_ifs.sv
`default_nettype none
interface p224ms_in_if
    import p224ms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] a_limb0;
    logic [LIMB_W-1:0] a_limb1;
    logic [LIMB_W-1:0] a_limb2;
    logic [TOP_W-1:0]  a_limb3;

    modport source (output valid, a_limb0, a_limb1, a_limb2, a_limb3, input ready);
    modport sink   (input valid, a_limb0, a_limb1, a_limb2, a_limb3, output ready);
endinterface

interface p224ms_out_if
    import p224ms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] square_limb0;
    logic [LIMB_W-1:0] square_limb1;
    logic [LIMB_W-1:0] square_limb2;
    logic [TOP_W-1:0]  square_limb3;

    modport source (output valid, square_limb0, square_limb1, square_limb2, square_limb3,
                    input ready);
    modport sink   (input valid, square_limb0, square_limb1, square_limb2, square_limb3,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/p224_montgomery_square.sv
`default_nettype none
// Channel  | Role  | Payload
// operand  | sink  | a_limb0..a_limb2 (64b), a_limb3 (32b)
// square   | src   | square_limb0..square_limb2 (64b), square_limb3 (32b)
//
// Ten register stages: 32x32 partial products, four stages of row adds,
// four reduction rounds (one per word), a final subtract of p.
// Accepts one beat per cycle unless square.ready stalls the full pipeline.
// Reset clears only the stage valid bits.
// Each stage holds while it is full and the stage after it is stalled,
// so bubbles are squeezed out and no beat is lost or repeated.
module p224_montgomery_square
    import p224ms_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    p224ms_in_if.sink   operand,
    p224ms_out_if.source square
);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    digit_t [NDIG-1:0] dig;
    row_t   [NDIG-1:0] row_next;
    row_t   [NDIG-1:0] row_reg;
    row_t sa_reg, sb_reg, sc_reg, r0a_reg;
    row_t t_reg, sc2_reg, r0b_reg;
    row_t v_reg, r0c_reg;
    row_t prod_reg;
    logic [ACC1_W-1:0] acc1;
    logic [ACC2_W-1:0] acc2;
    logic [ACC3_W-1:0] acc3;
    logic [ACC4_W-1:0] acc4;
    logic [ACC4_W:0]   diff;
    logic [FE_W-1:0]   res_next;
    logic [FE_W-1:0]   res_reg;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || square.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign operand.ready = en[0];
    assign square.valid  = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= operand.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign dig = {operand.a_limb3, operand.a_limb2, operand.a_limb1, operand.a_limb0};

    // diagonal d holds products dig[i]*dig[i+d]; they never overlap
    always_comb
    begin
        row_next = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            for (int i = 0; i + d < NDIG; i++)
            begin
                row_next[d][DIG_W*(2*i+d) +: 2*DIG_W] =
                    (2*DIG_W)'(dig[i]) * (2*DIG_W)'(dig[i+d]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            row_reg <= row_next;
        end
        if (en[1])
        begin
            sa_reg  <= row_reg[1] + row_reg[2];
            sb_reg  <= row_reg[3] + row_reg[4];
            sc_reg  <= row_reg[5] + row_reg[6];
            r0a_reg <= row_reg[0];
        end
        if (en[2])
        begin
            t_reg   <= sa_reg + sb_reg;
            sc2_reg <= sc_reg;
            r0b_reg <= r0a_reg;
        end
        if (en[3])
        begin
            v_reg   <= t_reg + sc2_reg;
            r0c_reg <= r0b_reg;
        end
        if (en[4])
        begin
            // off-diagonal products count twice
            prod_reg <= r0c_reg + (v_reg << 1);
        end
    end

    p224ms_round #(.IN_W(ACC0_W), .OUT_W(ACC1_W)) u_round0 (
        .clk(clk), .en(en[5]), .acc_in(prod_reg), .acc_out(acc1));
    p224ms_round #(.IN_W(ACC1_W), .OUT_W(ACC2_W)) u_round1 (
        .clk(clk), .en(en[6]), .acc_in(acc1), .acc_out(acc2));
    p224ms_round #(.IN_W(ACC2_W), .OUT_W(ACC3_W)) u_round2 (
        .clk(clk), .en(en[7]), .acc_in(acc2), .acc_out(acc3));
    p224ms_round #(.IN_W(ACC3_W), .OUT_W(ACC4_W)) u_round3 (
        .clk(clk), .en(en[8]), .acc_in(acc3), .acc_out(acc4));

    // accumulator is below 2p: one subtract fully reduces it
    always_comb
    begin
        diff = {1'b0, acc4} - (ACC4_W + 1)'(P224);
        if (diff[ACC4_W])
        begin
            res_next = acc4[FE_W-1:0];
        end
        else
        begin
            res_next = diff[FE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            res_reg <= res_next;
        end
    end

    assign square.square_limb0 = res_reg[LIMB_W-1:0];
    assign square.square_limb1 = res_reg[2*LIMB_W-1:LIMB_W];
    assign square.square_limb2 = res_reg[3*LIMB_W-1:2*LIMB_W];
    assign square.square_limb3 = res_reg[FE_W-1:3*LIMB_W];

endmodule
`default_nettype wire

FILE: rtl/core/p224ms_round.sv
`default_nettype none
module p224ms_round
    import p224ms_pkg::*;
#(
    parameter int unsigned IN_W  = 448,
    parameter int unsigned OUT_W = 385
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IN_W-1:0]  acc_in,
    output logic      [OUT_W-1:0] acc_out
);

    logic [LIMB_W-1:0] m;
    logic              cy;
    logic [OUT_W-1:0]  acc_reg;
    logic [OUT_W-1:0]  acc_next;

    // low word plus m is zero mod 2^64; it carries unless the word was zero
    assign m  = LIMB_W'(0) - acc_in[LIMB_W-1:0];
    assign cy = |acc_in[LIMB_W-1:0];

    always_comb
    begin
        acc_next = OUT_W'(acc_in[IN_W-1:LIMB_W]) + OUT_W'(cy)
                 + (OUT_W'(m) << M_HI_SH) - (OUT_W'(m) << M_LO_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule
`default_nettype wire
